// ===== src/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer package
// Shared types, register map and widths for the free-running timer with
// compare channels.
// ----------------------------------------------------------------------------
package frt_pkg;

    // Field and state widths.
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 64;
    localparam int ADDR_W       = 3;
    localparam int MODE_W       = 2;
    localparam int IRQ_W        = 4;

    // Channel limits. Only the first COMPARE_SLOTS channels have a bus address.
    localparam int MAX_CHANNELS = 8;
    localparam int NUM_CHANNELS_DEFAULT = 4;
    localparam int COMPARE_SLOTS = 4;

    // Register map.
    localparam logic [ADDR_W-1:0] ADDR_STATUS   = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_COUNT_LO = 3'd1;
    localparam logic [ADDR_W-1:0] ADDR_COUNT_HI = 3'd2;
    localparam logic [ADDR_W-1:0] ADDR_COMPARE0 = 3'd3;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

    // One input beat.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] reg_address;
        logic [DATA_W-1:0] write_data;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_lines;
    } t_result;

endpackage

// ===== src/frt_core.sv =====
// ----------------------------------------------------------------------------
// Timer core
// Holds the tick counter, compare registers and match flags, and works out
// the result of one beat in a single pass of logic.
// ----------------------------------------------------------------------------
module frt_core #(
    parameter int NUM_CHANNELS = frt_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  frt_pkg::t_item  i_item,
    output frt_pkg::t_result o_result
);

    logic [frt_pkg::COUNT_W-1:0] r_count;
    logic [frt_pkg::COUNT_W-1:0] n_count;
    logic [frt_pkg::DATA_W-1:0]  r_compare [NUM_CHANNELS];
    logic [frt_pkg::DATA_W-1:0]  n_compare [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]     r_flags;
    logic [NUM_CHANNELS-1:0]     n_flags;

    logic [frt_pkg::DATA_W-1:0]       w_count_lo_inc;
    logic [NUM_CHANNELS-1:0]          w_match;
    logic [frt_pkg::DATA_W-1:0]       w_read_data;
    logic [frt_pkg::MAX_CHANNELS-1:0] w_flags_pad;

    // Low word of the incremented counter, for the compare match.
    assign w_count_lo_inc = r_count[frt_pkg::DATA_W-1:0] + frt_pkg::DATA_W'(1);

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            w_match[i] = (r_compare[i] == w_count_lo_inc);
        end
    end

    // Register read mux; addresses without a register read zero.
    always_comb begin
        w_read_data = '0;
        case (i_item.reg_address)
            frt_pkg::ADDR_STATUS: begin
                w_read_data = frt_pkg::DATA_W'(r_flags);
            end
            frt_pkg::ADDR_COUNT_LO: begin
                w_read_data = r_count[frt_pkg::DATA_W-1:0];
            end
            frt_pkg::ADDR_COUNT_HI: begin
                w_read_data = r_count[frt_pkg::COUNT_W-1:frt_pkg::DATA_W];
            end
            default: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (i < frt_pkg::COMPARE_SLOTS &&
                        i_item.reg_address ==
                            frt_pkg::ADDR_W'(int'(frt_pkg::ADDR_COMPARE0) + i)) begin
                        w_read_data = w_read_data | r_compare[i];
                    end
                end
            end
        endcase
    end

    // Next state for the current beat.
    always_comb begin
        n_count   = r_count;
        n_compare = r_compare;
        n_flags   = r_flags;
        case (frt_pkg::t_mode'(i_item.mode))
            frt_pkg::MODE_TICK: begin
                n_count = r_count + frt_pkg::COUNT_W'(1);
                n_flags = r_flags | w_match;
            end
            frt_pkg::MODE_WRITE: begin
                if (i_item.reg_address == frt_pkg::ADDR_STATUS) begin
                    n_flags = r_flags & ~i_item.write_data[NUM_CHANNELS-1:0];
                end
                // Channels past the addressable slots keep their reset value.
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (i < frt_pkg::COMPARE_SLOTS &&
                        i_item.reg_address ==
                            frt_pkg::ADDR_W'(int'(frt_pkg::ADDR_COMPARE0) + i)) begin
                        n_compare[i] = i_item.write_data;
                    end
                end
            end
            default: begin
                // Reads and the unused code leave the state alone.
            end
        endcase
    end

    // Result fields: read data only for reads, flags after the beat.
    assign w_flags_pad = frt_pkg::MAX_CHANNELS'(n_flags);

    always_comb begin
        o_result.irq_lines = w_flags_pad[frt_pkg::IRQ_W-1:0];
        if (frt_pkg::t_mode'(i_item.mode) == frt_pkg::MODE_READ) begin
            o_result.read_data = w_read_data;
        end else begin
            o_result.read_data = '0;
        end
    end

    // State registers advance once per beat that moves to the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flags <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_compare[i] <= '0;
            end
        end else if (i_fire) begin
            r_count   <= n_count;
            r_flags   <= n_flags;
            r_compare <= n_compare;
        end
    end

endmodule

// ===== src/free_running_timer_compare_channels.sv =====
// ----------------------------------------------------------------------------
// Free-running timer with compare channels
// A 64-bit tick counter with compare-match flags, driven by a stream of
// tick, read and write beats.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_mode, i_reg_address,
//                                                 i_write_data
//   out      output     o_out_valid / i_out_ready o_read_data, o_irq_lines
//
// One beat is accepted every cycle unless the output stalls; its result passes
// through the input register and the result register.
// The single pass of logic (a 64-bit increment and the 32-bit compares)
// between those registers sets the cycle time.
// Reset is synchronous and clears the counter, compare values and flags.
// A stalled output holds its beat while one more beat waits in the input
// register; only then does o_in_ready drop.
// ----------------------------------------------------------------------------
module free_running_timer_compare_channels #(
    parameter int NUM_CHANNELS = frt_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [frt_pkg::MODE_W-1:0]  i_mode,
    input  logic [frt_pkg::ADDR_W-1:0]  i_reg_address,
    input  logic [frt_pkg::DATA_W-1:0]  i_write_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [frt_pkg::DATA_W-1:0]  o_read_data,
    output logic [frt_pkg::IRQ_W-1:0]   o_irq_lines
);

    logic             r_in_valid;
    frt_pkg::t_item   r_in;
    logic             r_out_valid;
    frt_pkg::t_result r_out;
    frt_pkg::t_result w_result;
    logic             w_fire;

    // The held beat moves on when the result register is free or draining.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.mode        <= i_mode;
            r_in.reg_address <= i_reg_address;
            r_in.write_data  <= i_write_data;
        end
    end

    frt_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out.read_data;
    assign o_irq_lines = r_out.irq_lines;

endmodule

// ===== src/frt_checker.sv =====
// ----------------------------------------------------------------------------
// Timer port checker
// Watches the timer's ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module frt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [frt_pkg::DATA_W-1:0]  o_read_data,
    input logic [frt_pkg::IRQ_W-1:0]   o_irq_lines
);

    // A result beat that is not taken stays valid with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_data) && $stable(o_irq_lines))
        else $error("result beat changed while stalled");

    // No result beat is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // The input side only stalls when a result is waiting and not taken.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // An accepted beat reaches the output when the result register is not blocked.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 (!o_out_valid || i_out_ready) |=> o_out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind free_running_timer_compare_channels frt_checker u_frt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_read_data   (o_read_data),
    .o_irq_lines   (o_irq_lines)
);

// ===== dv/timer_compare_checker.sv =====
// ----------------------------------------------------------------------------
// Timer compare checker
// Watches both channels of the free-running timer. Every accepted input beat
// runs through a local model of the counter, compare registers and match
// flags. The expected result is queued, and each accepted output beat is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module timer_compare_checker #(
    parameter int NUM_CHANNELS = frt_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [frt_pkg::MODE_W-1:0]  i_mode,
    input  logic [frt_pkg::ADDR_W-1:0]  i_reg_address,
    input  logic [frt_pkg::DATA_W-1:0]  i_write_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [frt_pkg::DATA_W-1:0]  i_read_data,
    input  logic [frt_pkg::IRQ_W-1:0]   i_irq_lines,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results_checked,
    output int                          o_irq_results
);
    import frt_pkg::*;

    // Local copy of the timer state.
    logic [COUNT_W-1:0]      tick_count_q;
    logic [DATA_W-1:0]       compare_q [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] flags_q;

    // Results expected from the block, oldest first.
    t_result pending_results[$];

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        o_fail_count++;
    endtask

    // Applies one beat to the local timer state and returns its result.
    function automatic t_result timer_step(input t_item beat);
        t_result                 res;
        logic [MAX_CHANNELS-1:0] chan_mask;
        int                      slot;
        res       = '0;
        chan_mask = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) chan_mask[i] = 1'b1;
        // A compare address maps to a channel only inside the addressable window.
        slot = -1;
        if (beat.reg_address >= ADDR_COMPARE0) begin
            slot = int'(beat.reg_address - ADDR_COMPARE0);
            if (slot >= COMPARE_SLOTS || slot >= NUM_CHANNELS) slot = -1;
        end
        case (beat.mode)
            MODE_TICK: begin
                tick_count_q = tick_count_q + 1'b1;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (compare_q[i] == tick_count_q[DATA_W-1:0]) flags_q[i] = 1'b1;
                end
            end
            MODE_READ: begin
                case (beat.reg_address)
                    ADDR_STATUS:   res.read_data = DATA_W'(flags_q);
                    ADDR_COUNT_LO: res.read_data = tick_count_q[DATA_W-1:0];
                    ADDR_COUNT_HI: res.read_data = tick_count_q[COUNT_W-1:DATA_W];
                    default:       res.read_data = (slot >= 0) ? compare_q[slot] : '0;
                endcase
            end
            MODE_WRITE: begin
                // Status writes clear flags; counter writes fall through unused.
                if (beat.reg_address == ADDR_STATUS) begin
                    flags_q = flags_q & ~(beat.write_data[MAX_CHANNELS-1:0] & chan_mask);
                end else if (slot >= 0) begin
                    compare_q[slot] = beat.write_data;
                end
            end
            default: ;
        endcase
        res.irq_lines = flags_q[IRQ_W-1:0];
        return res;
    endfunction

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_results_checked = 0;
        o_irq_results     = 0;
    end

    // Predict on input beats and compare on output beats.
    always @(posedge i_clk) begin
        t_item   beat;
        t_result want;
        if (!i_rst_n) begin
            tick_count_q = '0;
            flags_q      = '0;
            for (int i = 0; i < MAX_CHANNELS; i++) compare_q[i] = '0;
            pending_results.delete();
        end else begin
            if ($isunknown(i_out_valid) || $isunknown(i_in_ready)) begin
                report_mismatch("handshake level known", '0, DATA_W'({i_out_valid, i_in_ready}));
            end
            if (i_in_valid && i_in_ready) begin
                beat.mode        = i_mode;
                beat.reg_address = i_reg_address;
                beat.write_data  = i_write_data;
                pending_results.push_back(timer_step(beat));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, i_read_data);
                end else begin
                    want = pending_results.pop_front();
                    if (i_read_data !== want.read_data) begin
                        report_mismatch("read_data", want.read_data, i_read_data);
                    end
                    if (i_irq_lines !== want.irq_lines) begin
                        report_mismatch("irq_lines", DATA_W'(want.irq_lines),
                                        DATA_W'(i_irq_lines));
                    end
                    o_results_checked++;
                    if (want.irq_lines != '0) o_irq_results++;
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== dv/free_running_timer_compare_channels_tb.sv =====
// ----------------------------------------------------------------------------
// Free-running timer testbench
// Drives tick, read and write beats into the timer under four flow-control
// phases and lets the compare checker judge every result. A directed opening
// covers the register map and the corner cases, then random traffic keeps
// compare values just ahead of the counter so that matches happen often.
// ----------------------------------------------------------------------------
module free_running_timer_compare_channels_tb;
    import frt_pkg::*;

    localparam int                NUM_CHANNELS  = NUM_CHANNELS_DEFAULT;
    localparam int                CYCLE_LIMIT   = 200000;
    localparam int                BEATS_PER_PHASE = 144;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [MODE_W-1:0] i_mode;
    logic [ADDR_W-1:0] i_reg_address;
    logic [DATA_W-1:0] i_write_data;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic [IRQ_W-1:0]  o_irq_lines;

    int                fail_count;
    int                pending;
    int                results_checked;
    int                irq_results;
    int                cycle_count = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                beats_sent = 0;
    logic [COUNT_W-1:0] ticks_sent = '0;

    always #5 i_clk = ~i_clk;

    free_running_timer_compare_channels #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_reg_address (i_reg_address),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_irq_lines   (o_irq_lines)
    );

    timer_compare_checker #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_reg_address     (i_reg_address),
        .i_write_data      (i_write_data),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_read_data       (o_read_data),
        .i_irq_lines       (o_irq_lines),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_irq_results     (irq_results)
    );

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one beat, with an optional idle gap first, and waits until it
    // is accepted. Valid stays high on return so back-to-back beats need no
    // extra edge.
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_reg_address <= addr;
        i_write_data  <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (mode == MODE_TICK) ticks_sent = ticks_sent + 1'b1;
        beats_sent++;
    endtask

    // Mostly well-formed traffic: ticks, reads, compare values placed just
    // ahead of the counter and flag clears, with some unused codes mixed in.
    task automatic send_random_beat();
        int unsigned       pick;
        logic [DATA_W-1:0] near;
        logic [ADDR_W-1:0] counter_addr;
        pick = $urandom_range(99);
        near = ticks_sent[DATA_W-1:0] + DATA_W'($urandom_range(0, 8));
        // A counter word, or now and then the unmapped address.
        counter_addr = ADDR_W'($urandom_range(1, 2))
                     | (ADDR_W'($urandom_range(0, 1)) * ADDR_UNMAPPED);
        if (pick < 40) begin
            send_beat(MODE_TICK, ADDR_W'($urandom), $urandom);
        end else if (pick < 58) begin
            send_beat(MODE_READ, ADDR_W'($urandom_range(0, 7)), $urandom);
        end else if (pick < 74) begin
            send_beat(MODE_WRITE, ADDR_COMPARE0 + ADDR_W'($urandom_range(0, 3)), near);
        end else if (pick < 85) begin
            send_beat(MODE_WRITE, ADDR_STATUS, $urandom);
        end else if (pick < 90) begin
            send_beat(MODE_SPARE, ADDR_W'($urandom), $urandom);
        end else if (pick < 95) begin
            send_beat(MODE_WRITE, counter_addr, $urandom);
        end else begin
            send_beat(MODE_WRITE, ADDR_COMPARE0 + ADDR_W'($urandom_range(0, 3)), $urandom);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_mode        <= MODE_TICK;
        i_reg_address <= ADDR_STATUS;
        i_write_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every address reads back its reset value; the unmapped one reads zero.
        for (int a = 0; a < 8; a++) send_beat(MODE_READ, ADDR_W'(a), $urandom);
        // Spare mode and writes to the counter or unmapped space change nothing.
        send_beat(MODE_SPARE, ADDR_COMPARE0, '1);
        send_beat(MODE_WRITE, ADDR_COUNT_LO, '1);
        send_beat(MODE_WRITE, ADDR_COUNT_HI, '1);
        send_beat(MODE_WRITE, ADDR_UNMAPPED, 32'hA5A5_A5A5);
        // Load the compare values; channel 3 first holds the current count, then takes 1.
        send_beat(MODE_WRITE, ADDR_COMPARE0 + 3'd3, 32'd0);
        send_beat(MODE_WRITE, ADDR_COMPARE0, 32'd2);
        send_beat(MODE_WRITE, ADDR_COMPARE0 + 3'd1, 32'd2);
        send_beat(MODE_WRITE, ADDR_COMPARE0 + 3'd2, '1);
        send_beat(MODE_WRITE, ADDR_COMPARE0 + 3'd3, 32'd1);
        // Channel 3 matches on the first tick, channels 0 and 1 on the second.
        send_beat(MODE_TICK, ADDR_STATUS, '0);
        send_beat(MODE_TICK, ADDR_STATUS, '0);
        send_beat(MODE_READ, ADDR_STATUS, '0);
        // Bits above the channel count are ignored, then single and full clears.
        send_beat(MODE_WRITE, ADDR_STATUS, 32'hFFFF_FFF0);
        send_beat(MODE_WRITE, ADDR_STATUS, 32'h0000_0001);
        send_beat(MODE_WRITE, ADDR_STATUS, '1);
        send_beat(MODE_READ, ADDR_COUNT_LO, '0);
        send_beat(MODE_READ, ADDR_COUNT_HI, '0);

        // Random traffic under each flow-control phase.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 57; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 57; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            repeat (BEATS_PER_PHASE) send_random_beat();
        end

        // Drain the remaining results, then allow for the pipeline latency.
        i_in_valid <= 1'b0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d beats (%0d ticks) across four flow-control phases.",
                 beats_sent, ticks_sent);
        $display("Checked %0d results, %0d of them with a compare interrupt raised.",
                 results_checked, irq_results);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
